FILE: hdl/ams_pkg.sv
// Package: widths, command codes, sequencer states and CORDIC tables for the matrix stack.
`default_nettype none
package ams_pkg;
   localparam int StackDepth  = 16;
   localparam int CordicSteps = 16;
   localparam int IdxW   = (StackDepth > 1) ? $clog2(StackDepth) : 1;
   localparam int MemDepth = StackDepth * 6;
   localparam int AddrW  = $clog2(MemDepth);
   localparam int StepW  = $clog2(CordicSteps + 1);

   localparam logic signed [31:0] OneQ16 = 32'sd65536;
   localparam logic signed [33:0] Deg360 = 34'sd23592960;
   localparam logic signed [33:0] Deg180 = 34'sd11796480;
   localparam logic signed [33:0] Deg90  = 34'sd5898240;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   // 92 full turns: lifts any 32-bit angle to a positive value
   localparam logic signed [33:0] AngleBias = 34'sd2170552320;

   typedef enum logic [3:0] {
      CMD_NOP = 4'd0, CMD_PUSH = 4'd1, CMD_POP = 4'd2, CMD_IDENT = 4'd3,
      CMD_LOAD = 4'd4, CMD_MUL = 4'd5, CMD_ROT = 4'd6, CMD_SCALE = 4'd7,
      CMD_TRANS = 4'd8
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_RWAIT, ST_COPY, ST_REDUCE, ST_CORDIC, ST_PIVOT,
      ST_PROD, ST_WRITE, ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
   } mul_op_type;

   function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
      logic signed [31:0] r;
      case (i)
         5'd0: r = 32'sd2949120;  5'd1: r = 32'sd1740967; 5'd2: r = 32'sd919879;
         5'd3: r = 32'sd466945;   5'd4: r = 32'sd234379;  5'd5: r = 32'sd117304;
         5'd6: r = 32'sd58666;    5'd7: r = 32'sd29335;   5'd8: r = 32'sd14668;
         5'd9: r = 32'sd7334;     5'd10: r = 32'sd3667;   5'd11: r = 32'sd1833;
         5'd12: r = 32'sd917;     5'd13: r = 32'sd458;    5'd14: r = 32'sd229;
         5'd15: r = 32'sd115;     5'd16: r = 32'sd57;     5'd17: r = 32'sd29;
         5'd18: r = 32'sd14;      5'd19: r = 32'sd7;      5'd20: r = 32'sd4;
         5'd21: r = 32'sd2;       5'd22: r = 32'sd1;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sd2147483647) return 32'sh7fffffff;
      if (v < -50'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

FILE: hdl/ams_if.sv
// Interfaces: request and response channels of the matrix stack.
`default_nettype none
interface ams_req_if;
   logic valid;
   logic ready;
   logic [3:0] command;
   logic signed [31:0] in_m11, in_m12, in_m21, in_m22, in_m31, in_m32;
   logic signed [31:0] angle_deg, scale_factor, point_x, point_y;
   modport source (output valid, command, in_m11, in_m12, in_m21, in_m22, in_m31,
                   in_m32, angle_deg, scale_factor, point_x, point_y, input ready);
   modport sink (input valid, command, in_m11, in_m12, in_m21, in_m22, in_m31,
                 in_m32, angle_deg, scale_factor, point_x, point_y, output ready);
endinterface

interface ams_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] top_m11, top_m12, top_m21, top_m22, top_m31, top_m32;
   logic [4:0] stack_depth;
   logic push_refused;
   modport source (output valid, top_m11, top_m12, top_m21, top_m22, top_m31,
                   top_m32, stack_depth, push_refused, input ready);
   modport sink (input valid, top_m11, top_m12, top_m21, top_m22, top_m31,
                 top_m32, stack_depth, push_refused, output ready);
endinterface
`default_nettype wire

FILE: hdl/ams_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module ams_ram #(
   parameter int Width = 32,
   parameter int Depth = 96
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write one word, read one word; the read data is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hdl/ams_mul.sv
// Shared Q16.16 multiplier: registered 48-bit product rounded to Q32.16.
`default_nettype none
module ams_mul (
   input  wire logic               clock,
   input  wire ams_pkg::mul_op_type op,
   output      logic signed [47:0] prod_ff
);
   logic signed [63:0] full;
   logic signed [47:0] prod_in;

   // round half up, floor shift by 16
   always_comb begin
      full    = 64'(op.a) * 64'(op.b) + 64'sd32768;
      prod_in = full[63:16];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

FILE: hdl/affine_matrix_stack.sv
// Top level: matrix stack sequencer with shared multiplier, CORDIC and stack RAM.
//
//  channel  dir  beat
//  req_     in   command, in_m11..in_m32, angle_deg, scale_factor, point_x, point_y
//  rsp_     out  top_m11..top_m32, stack_depth, push_refused
//
// One command at a time; ready stays low until the response beat has been taken.
// Every command first reads the top entry. Nop, pop, unknown codes and a refused push
// then respond; push copies that entry to the new top; identity and load write the top;
// multiply and translate run the products; scale adds pivot products first; rotate
// also reduces the angle and runs 16 CORDIC steps before those. After reset, identity is
// written into entry 0 before the first accept.
`default_nettype none
module affine_matrix_stack (
   input wire logic clock,
   input wire logic reset,
   ams_req_if.sink   req,
   ams_rsp_if.source rsp
);
   localparam int IdxW  = ams_pkg::IdxW;
   localparam int AddrW = ams_pkg::AddrW;

   ams_pkg::state_type state_ff, state_in;
   logic [3:0] cmd_ff, cmd_in;
   logic [IdxW-1:0] top_ff, top_in;
   logic init_ff, init_in;
   logic refused_ff, refused_in;
   logic [3:0] cnt_ff, cnt_in;
   logic signed [31:0] a_ff [6];
   logic signed [31:0] b_ff [6];
   logic signed [31:0] r_ff [6];
   logic signed [49:0] acc_ff, acc_in;
   logic signed [31:0] px_ff, py_ff, ang_ff, f_ff;
   logic signed [33:0] z_ff, z_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic neg_ff, neg_in;
   logic [ams_pkg::StepW-1:0] step_ff, step_in;
   logic rvalid_ff, rvalid_in;

   logic wr_en;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data;
   ams_pkg::mul_op_type mop;
   logic signed [47:0] prod;

   logic signed [33:0] sc_s, sc_c;
   logic signed [33:0] cx_r, cy_r;

   ams_ram #(.Width(32), .Depth(ams_pkg::MemDepth)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   ams_mul u_mul (.clock(clock), .op(mop), .prod_ff(prod));

   function automatic logic [AddrW-1:0] waddr(input logic [IdxW-1:0] t, input logic [3:0] k);
      return AddrW'(t * 6 + k);
   endfunction

   // final CORDIC rounding and sign fold
   always_comb begin
      cx_r = (cx_ff + 34'sd8192) >>> 14;
      cy_r = (cy_ff + 34'sd8192) >>> 14;
      sc_c = neg_ff ? -cx_r : cx_r;
      sc_s = neg_ff ? -cy_r : cy_r;
   end

   // operand select for the shared multiplier, product index in cnt_ff
   always_comb begin
      mop = '{a: '0, b: '0};
      if (state_ff == ams_pkg::ST_PIVOT) begin
         if (cmd_ff == ams_pkg::CMD_ROT) begin
            case (cnt_ff[1:0])
               2'd0: mop = '{a: px_ff, b: sc_c[31:0]};
               2'd1: mop = '{a: py_ff, b: sc_s[31:0]};
               2'd2: mop = '{a: px_ff, b: sc_s[31:0]};
               default: mop = '{a: py_ff, b: sc_c[31:0]};
            endcase
         end else begin
            mop = '{a: f_ff, b: cnt_ff[0] ? py_ff : px_ff};
         end
      end else if (cnt_ff < 4'd12) begin
         // product k: element (k/4) row, pick a(row*2+half) times b(half*2+col)
         mop.a = a_ff[3'((cnt_ff >> 2) * 2) + 3'(cnt_ff[0])];
         mop.b = b_ff[3'(cnt_ff[0] * 2) + 3'(cnt_ff[1])];
      end
   end

   // sequencer
   always_comb begin
      logic signed [33:0] dx, dy, turn;
      state_in = state_ff; cmd_in = cmd_ff; top_in = top_ff; init_in = init_ff;
      refused_in = refused_ff; cnt_in = cnt_ff; acc_in = acc_ff;
      z_in = z_ff; cx_in = cx_ff; cy_in = cy_ff; neg_in = neg_ff; step_in = step_ff;
      rvalid_in = rvalid_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0;
      rd_addr = waddr(top_ff, cnt_ff);
      dx = cy_ff >>> step_ff;
      dy = cx_ff >>> step_ff;
      turn = ams_pkg::Deg360 <<< (3'd7 - cnt_ff[2:0]);
      req.ready = 1'b0;
      if (rsp.valid && rsp.ready) rvalid_in = 1'b0;
      case (state_ff)
         ams_pkg::ST_IDLE: begin
            if (init_ff) begin
               // write identity into entry 0
               wr_en = 1'b1; wr_addr = AddrW'(cnt_ff);
               wr_data = (cnt_ff == 4'd0 || cnt_ff == 4'd3) ? ams_pkg::OneQ16 : 32'd0;
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd5) begin init_in = 1'b0; cnt_in = '0; end
            end else if (!rvalid_ff) begin
               req.ready = 1'b1;
               if (req.valid) begin
                  cmd_in = req.command; cnt_in = '0; refused_in = 1'b0;
                  state_in = ams_pkg::ST_READ;
                  if (req.command == ams_pkg::CMD_POP && top_ff != '0)
                     top_in = top_ff - 1'b1;
               end
            end
         end
         ams_pkg::ST_READ: begin
            // issue six reads; data lands in the next cycle
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd5) state_in = ams_pkg::ST_RWAIT;
         end
         ams_pkg::ST_RWAIT: begin
            cnt_in = '0;
            case (cmd_ff)
               ams_pkg::CMD_PUSH: begin
                  if (32'(top_ff) + 1 >= ams_pkg::StackDepth) begin
                     refused_in = 1'b1; state_in = ams_pkg::ST_DONE;
                  end else begin
                     top_in = top_ff + 1'b1; state_in = ams_pkg::ST_COPY;
                  end
               end
               ams_pkg::CMD_IDENT, ams_pkg::CMD_LOAD: state_in = ams_pkg::ST_WRITE;
               ams_pkg::CMD_MUL, ams_pkg::CMD_TRANS: state_in = ams_pkg::ST_PROD;
               ams_pkg::CMD_SCALE: state_in = ams_pkg::ST_PIVOT;
               ams_pkg::CMD_ROT: begin
                  z_in = 34'(ang_ff) + ams_pkg::AngleBias;
                  state_in = ams_pkg::ST_REDUCE;
               end
               default: state_in = ams_pkg::ST_DONE;
            endcase
         end
         ams_pkg::ST_COPY: begin
            wr_en = 1'b1; wr_addr = waddr(top_ff, cnt_ff); wr_data = a_ff[cnt_ff[2:0]];
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd5) state_in = ams_pkg::ST_DONE;
         end
         ams_pkg::ST_REDUCE: begin
            // reduce modulo 360 by restoring subtraction, then fold into [-90, 90]
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff < 4'd8) begin
               if (z_ff >= turn) z_in = z_ff - turn;
            end else if (cnt_ff == 4'd8) begin
               if (z_ff > ams_pkg::Deg180) z_in = z_ff - ams_pkg::Deg360;
            end else begin
               neg_in = 1'b0;
               if (z_ff > ams_pkg::Deg90) begin
                  z_in = z_ff - ams_pkg::Deg180; neg_in = 1'b1;
               end else if (z_ff < -ams_pkg::Deg90) begin
                  z_in = z_ff + ams_pkg::Deg180; neg_in = 1'b1;
               end
               cx_in = ams_pkg::CordicGain; cy_in = '0; step_in = '0;
               state_in = ams_pkg::ST_CORDIC;
            end
         end
         ams_pkg::ST_CORDIC: begin
            // one micro-rotation a cycle
            if (z_ff >= 0) begin
               cx_in = cx_ff - dx; cy_in = cy_ff + dy;
               z_in = z_ff - 34'(ams_pkg::atan_q16(5'(step_ff)));
            end else begin
               cx_in = cx_ff + dx; cy_in = cy_ff - dy;
               z_in = z_ff + 34'(ams_pkg::atan_q16(5'(step_ff)));
            end
            step_in = step_ff + 1'b1;
            if (32'(step_ff) == ams_pkg::CordicSteps - 1) begin
               cnt_in = '0; state_in = ams_pkg::ST_PIVOT;
            end
         end
         ams_pkg::ST_PIVOT: begin
            // pivot products, b rows filled as results return
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd0) acc_in = 50'(px_ff);
            if (cmd_ff == ams_pkg::CMD_ROT) begin
               case (cnt_ff)
                  4'd1: acc_in = acc_ff - 50'(prod);
                  4'd2: acc_in = acc_ff + 50'(prod);
                  4'd3: acc_in = 50'(py_ff) - 50'(prod);
                  4'd4: acc_in = acc_ff - 50'(prod);
                  default: ;
               endcase
               if (cnt_ff == 4'd5) begin cnt_in = '0; state_in = ams_pkg::ST_PROD; end
            end else begin
               case (cnt_ff)
                  4'd1: acc_in = 50'(py_ff) - 50'(prod);
                  default: ;
               endcase
               if (cnt_ff == 4'd2) begin cnt_in = '0; state_in = ams_pkg::ST_PROD; end
            end
         end
         ams_pkg::ST_PROD: begin
            // 12 products, pairs summed; result k/2 finishes at cnt 2,4,...
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff[0] == 1'b1 && cnt_ff != 4'd13) acc_in = 50'(prod);
            else if (cnt_ff != 4'd0) acc_in = acc_ff + 50'(prod);
            if (cnt_ff == 4'd13) begin cnt_in = '0; state_in = ams_pkg::ST_WRITE; end
         end
         ams_pkg::ST_WRITE: begin
            wr_en = 1'b1; wr_addr = waddr(top_ff, cnt_ff); wr_data = r_ff[cnt_ff[2:0]];
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd5) state_in = ams_pkg::ST_DONE;
         end
         ams_pkg::ST_DONE: begin
            rvalid_in = 1'b1; state_in = ams_pkg::ST_IDLE; cnt_in = '0;
         end
         default: state_in = ams_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ams_pkg::ST_IDLE; top_ff <= '0; init_ff <= 1'b1;
         cnt_ff <= '0; rvalid_ff <= 1'b0; step_ff <= '0;
      end else begin
         state_ff <= state_in; top_ff <= top_in; init_ff <= init_in;
         cnt_ff <= cnt_in; rvalid_ff <= rvalid_in; step_ff <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; refused_ff <= refused_in; acc_ff <= acc_in;
      z_ff <= z_in; cx_ff <= cx_in; cy_ff <= cy_in; neg_ff <= neg_in;
      if (state_ff == ams_pkg::ST_IDLE && req.ready && req.valid) begin
         px_ff <= req.point_x; py_ff <= req.point_y;
         ang_ff <= req.angle_deg; f_ff <= req.scale_factor;
         case (req.command)
            ams_pkg::CMD_IDENT: begin
               r_ff[0] <= ams_pkg::OneQ16; r_ff[1] <= '0; r_ff[2] <= '0;
               r_ff[3] <= ams_pkg::OneQ16; r_ff[4] <= '0; r_ff[5] <= '0;
            end
            ams_pkg::CMD_LOAD: begin
               r_ff[0] <= req.in_m11; r_ff[1] <= req.in_m12; r_ff[2] <= req.in_m21;
               r_ff[3] <= req.in_m22; r_ff[4] <= req.in_m31; r_ff[5] <= req.in_m32;
            end
            ams_pkg::CMD_TRANS: begin
               b_ff[0] <= ams_pkg::OneQ16; b_ff[1] <= '0; b_ff[2] <= '0;
               b_ff[3] <= ams_pkg::OneQ16; b_ff[4] <= req.point_x;
               b_ff[5] <= req.point_y;
            end
            ams_pkg::CMD_SCALE: begin
               b_ff[0] <= req.scale_factor; b_ff[1] <= '0; b_ff[2] <= '0;
               b_ff[3] <= req.scale_factor;
            end
            default: begin
               b_ff[0] <= req.in_m11; b_ff[1] <= req.in_m12; b_ff[2] <= req.in_m21;
               b_ff[3] <= req.in_m22; b_ff[4] <= req.in_m31; b_ff[5] <= req.in_m32;
            end
         endcase
      end
      // capture read data: read issued at cnt k lands at cnt k+1
      if ((state_ff == ams_pkg::ST_READ && cnt_ff != 4'd0) ||
          state_ff == ams_pkg::ST_RWAIT) begin
         a_ff[3'(cnt_ff - 4'd1)] <= rd_data;
         if (cmd_ff != ams_pkg::CMD_IDENT && cmd_ff != ams_pkg::CMD_LOAD)
            r_ff[3'(cnt_ff - 4'd1)] <= rd_data;
      end
      if (state_ff == ams_pkg::ST_PIVOT) begin
         if (cmd_ff == ams_pkg::CMD_ROT) begin
            if (cnt_ff == 4'd0) begin
               b_ff[0] <= sc_c[31:0]; b_ff[1] <= sc_s[31:0];
               b_ff[2] <= -sc_s[31:0]; b_ff[3] <= sc_c[31:0];
            end
            if (cnt_ff == 4'd3) b_ff[4] <= ams_pkg::sat32(acc_ff);
            if (cnt_ff == 4'd5) b_ff[5] <= ams_pkg::sat32(acc_ff);
         end else begin
            if (cnt_ff == 4'd1) b_ff[4] <= ams_pkg::sat32(50'(px_ff) - 50'(prod));
            if (cnt_ff == 4'd2) b_ff[5] <= ams_pkg::sat32(50'(py_ff) - 50'(prod));
         end
      end
      if (state_ff == ams_pkg::ST_PROD && cnt_ff != 4'd0 && cnt_ff[0] == 1'b0) begin
         case (cnt_ff)
            4'd2:  r_ff[0] <= ams_pkg::sat32(acc_ff + 50'(prod));
            4'd4:  r_ff[1] <= ams_pkg::sat32(acc_ff + 50'(prod));
            4'd6:  r_ff[2] <= ams_pkg::sat32(acc_ff + 50'(prod));
            4'd8:  r_ff[3] <= ams_pkg::sat32(acc_ff + 50'(prod));
            4'd10: r_ff[4] <= ams_pkg::sat32(acc_ff + 50'(prod) + 50'(b_ff[4]));
            4'd12: r_ff[5] <= ams_pkg::sat32(acc_ff + 50'(prod) + 50'(b_ff[5]));
            default: ;
         endcase
      end
   end

   // response beat
   always_comb begin
      rsp.valid = rvalid_ff;
      rsp.top_m11 = r_ff[0]; rsp.top_m12 = r_ff[1]; rsp.top_m21 = r_ff[2];
      rsp.top_m22 = r_ff[3]; rsp.top_m31 = r_ff[4]; rsp.top_m32 = r_ff[5];
      rsp.stack_depth = 5'(32'(top_ff) + 1);
      rsp.push_refused = refused_ff;
   end
endmodule
`default_nettype wire
